>>> rtl/olist_pkg.sv
// Shared types and constants for the ordered list engine.
package olist_pkg;

  localparam int CAPACITY = 32;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = 6;
  localparam int OUT_W    = 8;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_FIND      = 2'd3
  } cmd_t;

  // Write strobes for the three slot arrays; each array takes one write a cycle.
  typedef struct packed {
    logic               value_we;
    logic [SLOT_W-1:0]  value_addr;
    logic [VALUE_W-1:0] value_data;
    logic               next_we;
    logic [SLOT_W-1:0]  next_addr;
    logic [SLOT_W-1:0]  next_data;
    logic               prev_we;
    logic [SLOT_W-1:0]  prev_addr;
    logic [SLOT_W-1:0]  prev_data;
  } slot_wr_t;

  // Mark or release one slot in the occupancy flags.
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic [SLOT_W-1:0] slot;
  } alloc_ctl_t;

endpackage

>>> rtl/olist_slot_mem.sv
// Slot storage: value, next link and prev link arrays with registered read.
module olist_slot_mem (
  input  logic                              clk,
  input  olist_pkg::slot_wr_t               wr,
  input  logic                              rd_en,
  input  logic [olist_pkg::SLOT_W-1:0]      rd_addr,
  output logic [olist_pkg::VALUE_W-1:0]     rd_value,
  output logic [olist_pkg::SLOT_W-1:0]      rd_next,
  output logic [olist_pkg::SLOT_W-1:0]      rd_prev
);
  import olist_pkg::*;

  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic [SLOT_W-1:0]  next_mem  [CAPACITY];
  logic [SLOT_W-1:0]  prev_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.value_we) begin
      value_mem[wr.value_addr] <= wr.value_data;
    end
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
  end

  // Hold read data while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
      rd_prev  <= prev_mem[rd_addr];
    end
  end

endmodule

>>> rtl/olist_alloc.sv
// Slot occupancy flags and lowest-free-slot finder.
module olist_alloc (
  input  logic                         clk,
  input  logic                         rst,
  input  olist_pkg::alloc_ctl_t        ctl,
  output logic [olist_pkg::SLOT_W-1:0] free_slot
);
  import olist_pkg::*;

  logic [CAPACITY-1:0] used;
  logic [SLOT_W-1:0]   lowest_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (ctl.set_en) begin
        used[ctl.slot] <= 1'b1;
      end
      if (ctl.clr_en) begin
        used[ctl.slot] <= 1'b0;
      end
    end
  end

  // Scan downwards so the lowest free index wins.
  always_comb begin
    lowest_free = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        lowest_free = SLOT_W'(i);
      end
    end
  end

  // Register the result; the flags change before the finish step, ahead of the next word being taken.
  always_ff @(posedge clk) begin
    free_slot <= lowest_free;
  end

endmodule

>>> rtl/ordered_list_engine.sv
// Ordered list engine: a circular doubly linked list of signed values in a slot pool.
// Usage
//   Input stream (s_axis_*): one word per command. tuser carries the command
//   (insert front, insert back, remove first match, find), tdata the signed
//   32-bit value. A word is taken when tvalid and tready are both high.
//   Output stream (m_axis_*): exactly one word per command, in order:
//   found, full_reject and the entry count after the command.
// Sequence
//   A rejected insert, or a remove/find on an empty list, goes straight to the
//   finish step. An insert writes the new slot, closes the ring unless the list
//   was empty, then finishes. Remove and find walk the list from the front one
//   entry per cycle through the single registered read port of the slot memory
//   and the one shared value comparator, stopping at the first hit or after
//   count entries; a remove that hits then unlinks the entry before finishing.
//   tready is high only while the sequencer is idle.
// Reset
//   Synchronous, active high: list empty, all slots free, output word dropped.
//   Slot contents are not cleared; only slots in use are ever read.
// Back-pressure
//   The result sits in an output register; a new command is taken while it
//   waits, but the next result holds its final step until the old one leaves.
module ordered_list_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [olist_pkg::VALUE_W-1:0]   s_axis_tdata,   // [31:0] value (signed)
  input  olist_pkg::cmd_t                 s_axis_tuser,   // [1:0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [olist_pkg::OUT_W-1:0]     m_axis_tdata    // [0] found, [1] full_reject, [7:2] entry_count
);
  import olist_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INS_A  = 6'b000010,
    ST_INS_B  = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_UNLINK = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                    state;
  cmd_t                      cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [SLOT_W-1:0]         cur_slot;
  logic [SLOT_W-1:0]         front;
  logic [SLOT_W-1:0]         back;
  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        walk_left;
  logic                      found_q;
  logic                      reject_q;

  logic                      accept;
  logic                      is_insert;
  logic                      hit;
  logic                      out_load;
  logic                      rd_en;
  logic [SLOT_W-1:0]         rd_addr;
  logic [VALUE_W-1:0]        rd_value;
  logic [SLOT_W-1:0]         rd_next;
  logic [SLOT_W-1:0]         rd_prev;
  logic [SLOT_W-1:0]         free_slot;
  slot_wr_t                  wr;
  alloc_ctl_t                alloc_ctl;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_insert     = (s_axis_tuser == CMD_INS_FRONT) || (s_axis_tuser == CMD_INS_BACK);

  // Shared comparator: entry under the walk pointer against the command value.
  assign hit = (rd_value == value_q);

  // Load the output word in the final step once the output register is free.
  assign out_load = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  olist_slot_mem u_mem (
    .clk      (clk),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_next  (rd_next),
    .rd_prev  (rd_prev)
  );

  olist_alloc u_alloc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (alloc_ctl),
    .free_slot (free_slot)
  );

  // Read port: start the walk at the front, then follow next links.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front;
    if (accept && !is_insert && (count != '0)) begin
      rd_en   = 1'b1;
      rd_addr = front;
    end else if ((state == ST_WALK) && !hit && (walk_left != COUNT_W'(1))) begin
      rd_en   = 1'b1;
      rd_addr = rd_next;
    end
  end

  // Memory writes and occupancy updates for link and unlink steps.
  always_comb begin
    wr        = '0;
    alloc_ctl = '0;
    unique case (state)
      ST_INS_A: begin
        wr.value_we   = 1'b1;
        wr.value_addr = cur_slot;
        wr.value_data = value_q;
        wr.next_we    = 1'b1;
        wr.next_addr  = cur_slot;
        wr.next_data  = (count == '0) ? cur_slot : front;
        wr.prev_we    = 1'b1;
        wr.prev_addr  = cur_slot;
        wr.prev_data  = (count == '0) ? cur_slot : back;
        alloc_ctl.set_en = 1'b1;
        alloc_ctl.slot   = cur_slot;
      end
      ST_INS_B: begin
        // Close the ring around the new slot.
        wr.prev_we   = 1'b1;
        wr.prev_addr = front;
        wr.prev_data = cur_slot;
        wr.next_we   = 1'b1;
        wr.next_addr = back;
        wr.next_data = cur_slot;
      end
      ST_UNLINK: begin
        alloc_ctl.clr_en = 1'b1;
        alloc_ctl.slot   = cur_slot;
        if (count > COUNT_W'(1)) begin
          wr.next_we   = 1'b1;
          wr.next_addr = rd_prev;
          wr.next_data = rd_next;
          wr.prev_we   = 1'b1;
          wr.prev_addr = rd_next;
          wr.prev_data = rd_prev;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      front         <= '0;
      back          <= '0;
      count         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q     <= s_axis_tuser;
            value_q   <= s_axis_tdata;
            found_q   <= 1'b0;
            reject_q  <= 1'b0;
            walk_left <= count;
            if (is_insert) begin
              cur_slot <= free_slot;
              if (count >= COUNT_W'(CAPACITY)) begin
                reject_q <= 1'b1;
                state    <= ST_FINISH;
              end else begin
                state <= ST_INS_A;
              end
            end else begin
              cur_slot <= front;
              state    <= (count == '0) ? ST_FINISH : ST_WALK;
            end
          end
        end
        ST_INS_A: begin
          if (count == '0) begin
            front <= cur_slot;
            back  <= cur_slot;
            count <= count + COUNT_W'(1);
            state <= ST_FINISH;
          end else begin
            state <= ST_INS_B;
          end
        end
        ST_INS_B: begin
          if (cmd_q == CMD_INS_FRONT) begin
            front <= cur_slot;
          end else begin
            back <= cur_slot;
          end
          count <= count + COUNT_W'(1);
          state <= ST_FINISH;
        end
        ST_WALK: begin
          if (hit) begin
            found_q <= 1'b1;
            state   <= (cmd_q == CMD_REMOVE) ? ST_UNLINK : ST_FINISH;
          end else if (walk_left == COUNT_W'(1)) begin
            state <= ST_FINISH;
          end else begin
            walk_left <= walk_left - COUNT_W'(1);
            cur_slot  <= rd_next;
          end
        end
        ST_UNLINK: begin
          if (count <= COUNT_W'(1)) begin
            count <= '0;
            front <= '0;
            back  <= '0;
          end else begin
            if (cur_slot == front) begin
              front <= rd_next;
            end
            if (cur_slot == back) begin
              back <= rd_prev;
            end
            count <= count - COUNT_W'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free.
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output valid: raise on a load, drop once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output payload; loaded alongside m_axis_tvalid.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {ENTRY_W'(count), reject_q, found_q};
    end
  end

endmodule
